@@ rtl/core/ddo_pkg.sv @@
// shared constants, command and status types and the arctangent table for the odometry core
package ddo_pkg;

    // rotations per cordic pass, 12 to 32
    localparam int CORDIC_STEPS = 24;

    // configuration
    localparam logic [31:0] WHEEL_BASE_RESET = 32'd15729;
    localparam int          REG_WHEEL_BASE   = 0;

    // cordic start vector (gain compensated) and clamp limit, Q1.30
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;

    // radians Q.16 to binary angle, round(2^47 / pi)
    localparam logic [45:0] BAM_K    = 46'd44798133900177;
    localparam logic [31:0] BAM_K_LO = BAM_K[31:0];
    localparam logic [13:0] BAM_K_HI = BAM_K[45:32];

    // datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
    localparam logic [OP_W-1:0] OP_MUL_DL   = 5'd2;
    localparam logic [OP_W-1:0] OP_ST_DL    = 5'd3;
    localparam logic [OP_W-1:0] OP_MUL_DR   = 5'd4;
    localparam logic [OP_W-1:0] OP_ST_DR    = 5'd5;
    localparam logic [OP_W-1:0] OP_SUMS     = 5'd6;
    localparam logic [OP_W-1:0] OP_DIV_STEP = 5'd7;
    localparam logic [OP_W-1:0] OP_MUL_B0   = 5'd8;
    localparam logic [OP_W-1:0] OP_ACC_B0   = 5'd9;
    localparam logic [OP_W-1:0] OP_MUL_B1   = 5'd10;
    localparam logic [OP_W-1:0] OP_ACC_B1   = 5'd11;
    localparam logic [OP_W-1:0] OP_MUL_B2   = 5'd12;
    localparam logic [OP_W-1:0] OP_ACC_B2   = 5'd13;
    localparam logic [OP_W-1:0] OP_COR_INIT = 5'd14;
    localparam logic [OP_W-1:0] OP_COR_STEP = 5'd15;
    localparam logic [OP_W-1:0] OP_COR_DONE = 5'd16;
    localparam logic [OP_W-1:0] OP_MUL_H    = 5'd17;
    localparam logic [OP_W-1:0] OP_MUL_L    = 5'd18;
    localparam logic [OP_W-1:0] OP_ADD_POS  = 5'd19;
    localparam logic [OP_W-1:0] OP_DIV_INIT = 5'd20;
    localparam logic [OP_W-1:0] OP_DIV_FIN  = 5'd21;
    localparam logic [OP_W-1:0] OP_OUT      = 5'd22;

    // sel: second cordic pass, y axis, or turn rate division
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sel;
        logic [4:0]      step;
    } ddo_cmd_t;

    typedef struct packed {
        logic dt_zero;
    } ddo_stat_t;

    // arctangent of 2^-i as binary angle
    function automatic logic [29:0] atan_bam(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            5'd31: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/ddo_in_if.sv @@
// wheel speed input channel
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic        [31:0] elapsed_time;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;

    modport source (output valid, elapsed_time, left_speed, right_speed, input ready);
    modport sink   (input valid, elapsed_time, left_speed, right_speed, output ready);
endinterface

@@ rtl/core/ddo_out_if.sv @@
// pose and velocity result channel
interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic        [31:0] heading;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] linear_speed;
    logic signed [31:0] turn_rate;
    logic               zero_time;

    modport source (output valid, pos_x, pos_y, heading, quat_z, quat_w, linear_speed,
                    turn_rate, zero_time, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, quat_z, quat_w, linear_speed,
                    turn_rate, zero_time, output ready);
endinterface

@@ rtl/core/ddo_ctrl.sv @@
// sequencer that steps the odometry datapath through one transaction
module ddo_ctrl import ddo_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ddo_stat_t stat,
    output ddo_cmd_t  cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_MUL_DL   = 5'd1;
    localparam logic [4:0] S_ST_DL    = 5'd2;
    localparam logic [4:0] S_MUL_DR   = 5'd3;
    localparam logic [4:0] S_ST_DR    = 5'd4;
    localparam logic [4:0] S_SUMS     = 5'd5;
    localparam logic [4:0] S_DIV_T    = 5'd6;
    localparam logic [4:0] S_MUL_B0   = 5'd7;
    localparam logic [4:0] S_ACC_B0   = 5'd8;
    localparam logic [4:0] S_MUL_B1   = 5'd9;
    localparam logic [4:0] S_ACC_B1   = 5'd10;
    localparam logic [4:0] S_MUL_B2   = 5'd11;
    localparam logic [4:0] S_ACC_B2   = 5'd12;
    localparam logic [4:0] S_COR_INIT = 5'd13;
    localparam logic [4:0] S_COR_STEP = 5'd14;
    localparam logic [4:0] S_COR_DONE = 5'd15;
    localparam logic [4:0] S_MUL_H    = 5'd16;
    localparam logic [4:0] S_MUL_L    = 5'd17;
    localparam logic [4:0] S_ADD_POS  = 5'd18;
    localparam logic [4:0] S_DIV_INIT = 5'd19;
    localparam logic [4:0] S_DIV_S    = 5'd20;
    localparam logic [4:0] S_DIV_FIN  = 5'd21;
    localparam logic [4:0] S_OUT      = 5'd22;

    localparam logic [5:0] LAST_TURN_STEP = 6'd63;
    localparam logic [5:0] LAST_SAT_STEP  = 6'd31;
    localparam logic [5:0] LAST_COR_STEP  = 6'(CORDIC_STEPS - 1);

    logic [4:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       pass_reg, pass_next;
    logic       sel_reg, sel_next;
    logic       out_valid_reg, out_valid_next;
    logic       load_out;

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        sel_next   = sel_reg;
        load_out   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.sel    = sel_reg;
        cmd.step   = cnt_reg[4:0];
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    pass_next  = 1'b0;
                    sel_next   = 1'b0;
                    state_next = S_MUL_DL;
                end
            end
            S_MUL_DL:
            begin
                cmd.op     = OP_MUL_DL;
                state_next = S_ST_DL;
            end
            S_ST_DL:
            begin
                cmd.op     = OP_ST_DL;
                state_next = S_MUL_DR;
            end
            S_MUL_DR:
            begin
                cmd.op     = OP_MUL_DR;
                state_next = S_ST_DR;
            end
            S_ST_DR:
            begin
                cmd.op     = OP_ST_DR;
                state_next = S_SUMS;
            end
            S_SUMS:
            begin
                cmd.op     = OP_SUMS;
                cnt_next   = '0;
                state_next = S_DIV_T;
            end
            S_DIV_T:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == LAST_TURN_STEP)
                begin
                    state_next = S_MUL_B0;
                end
            end
            S_MUL_B0:
            begin
                cmd.op     = OP_MUL_B0;
                state_next = S_ACC_B0;
            end
            S_ACC_B0:
            begin
                cmd.op     = OP_ACC_B0;
                state_next = S_MUL_B1;
            end
            S_MUL_B1:
            begin
                cmd.op     = OP_MUL_B1;
                state_next = S_ACC_B1;
            end
            S_ACC_B1:
            begin
                cmd.op     = OP_ACC_B1;
                state_next = S_MUL_B2;
            end
            S_MUL_B2:
            begin
                cmd.op     = OP_MUL_B2;
                state_next = S_ACC_B2;
            end
            S_ACC_B2:
            begin
                cmd.op     = OP_ACC_B2;
                state_next = S_COR_INIT;
            end
            S_COR_INIT:
            begin
                cmd.op     = OP_COR_INIT;
                cmd.sel    = pass_reg;
                cnt_next   = '0;
                state_next = S_COR_STEP;
            end
            S_COR_STEP:
            begin
                cmd.op   = OP_COR_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == LAST_COR_STEP)
                begin
                    state_next = S_COR_DONE;
                end
            end
            S_COR_DONE:
            begin
                cmd.op   = OP_COR_DONE;
                cmd.sel  = pass_reg;
                sel_next = 1'b0;
                priority if (!pass_reg)
                begin
                    state_next = S_MUL_H;
                end
                else if (stat.dt_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DIV_INIT;
                end
            end
            S_MUL_H:
            begin
                cmd.op     = OP_MUL_H;
                state_next = S_MUL_L;
            end
            S_MUL_L:
            begin
                cmd.op     = OP_MUL_L;
                state_next = S_ADD_POS;
            end
            S_ADD_POS:
            begin
                cmd.op = OP_ADD_POS;
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = S_MUL_H;
                end
                else
                begin
                    pass_next  = 1'b1;
                    state_next = S_COR_INIT;
                end
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV_S;
            end
            S_DIV_S:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == LAST_SAT_STEP)
                begin
                    state_next = S_DIV_FIN;
                end
            end
            S_DIV_FIN:
            begin
                cmd.op = OP_DIV_FIN;
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = S_DIV_INIT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = OP_OUT;
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output slot holds a finished result until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pass_reg      <= 1'b0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pass_reg      <= pass_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/ddo_datapath.sv @@
// odometry datapath: shared multiplier, restoring divider, cordic and pose state
module ddo_datapath import ddo_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  ddo_cmd_t           cmd,
    output ddo_stat_t          stat,
    input  logic        [31:0] wheel_base,
    input  logic        [31:0] elapsed_time,
    input  logic signed [31:0] left_speed,
    input  logic signed [31:0] right_speed,
    output logic signed [47:0] pos_x,
    output logic signed [47:0] pos_y,
    output logic        [31:0] heading,
    output logic signed [31:0] quat_z,
    output logic signed [31:0] quat_w,
    output logic signed [31:0] linear_speed,
    output logic signed [31:0] turn_rate,
    output logic               zero_time
);

    // captured item
    logic        [31:0] dt_reg;
    logic        [31:0] ls_reg, rs_reg;
    // multiplier
    logic        [31:0] mul_a, mul_b;
    logic        [63:0] prod_reg;
    // wheel travel
    logic        [47:0] dl_reg, dr_reg;
    logic        [46:0] tmag_reg;
    logic               tneg_reg;
    logic               dneg_reg;
    // divider
    logic        [31:0] div_rem_reg, div_dsr_reg;
    logic        [63:0] div_dvd_reg, div_quo_reg;
    logic               div_ovf_reg;
    logic        [63:0] turn_reg;
    logic        [63:0] bacc_reg;
    // cordic
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               cflip_reg;
    logic signed [31:0] cos_reg, sin_reg, qz_reg, qw_reg;
    // position scaling
    logic        [61:0] sacc_reg;
    // pose state
    logic        [47:0] x_reg, y_reg;
    logic        [31:0] hd_reg;
    logic signed [31:0] lin_reg, rate_reg;
    // result slot
    logic        [47:0] ox_reg, oy_reg;
    logic        [31:0] ohd_reg;
    logic signed [31:0] oqz_reg, oqw_reg, olin_reg, orate_reg;
    logic               ozero_reg;

    logic        [31:0] ls_mag, rs_mag;
    logic signed [31:0] f_val;
    logic               f_neg;
    logic        [31:0] f_mag;
    logic        [47:0] dw_mag;
    logic        [47:0] dl_next, dr_next;
    logic        [48:0] sum49, diff49, smag49, dmag49;
    logic        [32:0] r2, r2m;
    logic               ge;
    logic        [31:0] rem_next;
    logic        [63:0] m64;
    logic        [47:0] m_hi;
    logic        [31:0] ang;
    logic               flip;
    logic signed [33:0] z0;
    logic signed [33:0] xs, ys, at;
    logic signed [31:0] cxc, cyc, c_res, s_res;
    logic        [77:0] sum78;
    logic        [47:0] m48, delta;
    logic        [31:0] bam, hstep;
    logic               sneg;
    logic        [31:0] lim, qv, sat, sres;

    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [31:0] r;
        priority if (v > ONE_Q30)
        begin
            r = 32'(ONE_Q30);
        end
        else if (v < -ONE_Q30)
        begin
            r = 32'(-ONE_Q30);
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign stat.dt_zero = (dt_reg == 32'd0);

    // magnitudes of the operands
    always_comb
    begin
        ls_mag = ls_reg[31] ? (32'd0 - ls_reg) : ls_reg;
        rs_mag = rs_reg[31] ? (32'd0 - rs_reg) : rs_reg;
        f_val  = cmd.sel ? sin_reg : cos_reg;
        f_neg  = f_val[31];
        f_mag  = f_neg ? (32'd0 - f_val) : f_val;
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MUL_DL:
            begin
                mul_a = dt_reg;
                mul_b = ls_mag;
            end
            OP_MUL_DR:
            begin
                mul_a = dt_reg;
                mul_b = rs_mag;
            end
            OP_MUL_B0:
            begin
                mul_a = div_quo_reg[31:0];
                mul_b = BAM_K_LO;
            end
            OP_MUL_B1:
            begin
                mul_a = turn_reg[31:0];
                mul_b = {18'd0, BAM_K_HI};
            end
            OP_MUL_B2:
            begin
                mul_a = turn_reg[63:32];
                mul_b = BAM_K_LO;
            end
            OP_MUL_H:
            begin
                mul_a = {1'b0, tmag_reg[46:16]};
                mul_b = f_mag;
            end
            OP_MUL_L:
            begin
                mul_a = {16'd0, tmag_reg[15:0]};
                mul_b = f_mag;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // wheel travel, mean and difference
    always_comb
    begin
        dw_mag  = {1'b0, prod_reg[62:16]};
        dl_next = ls_reg[31] ? (48'd0 - dw_mag) : dw_mag;
        dr_next = rs_reg[31] ? (48'd0 - dw_mag) : dw_mag;
        sum49   = {dl_reg[47], dl_reg} + {dr_reg[47], dr_reg};
        diff49  = {dr_reg[47], dr_reg} - {dl_reg[47], dl_reg};
        smag49  = sum49[48] ? (49'd0 - sum49) : sum49;
        dmag49  = diff49[48] ? (49'd0 - diff49) : diff49;
    end

    // restoring divider step and saturating-division setup
    always_comb
    begin
        r2       = {div_rem_reg, div_dvd_reg[63]};
        r2m      = r2 - {1'b0, div_dsr_reg};
        ge       = (r2 >= {1'b0, div_dsr_reg});
        rem_next = ge ? r2m[31:0] : r2[31:0];
        m64      = cmd.sel ? turn_reg : {17'd0, tmag_reg};
        m_hi     = m64[63:16];
        sneg     = cmd.sel ? dneg_reg : tneg_reg;
        lim      = sneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        qv       = div_quo_reg[31:0];
        sat      = (div_ovf_reg || (qv > lim)) ? lim : qv;
        sres     = sneg ? (32'd0 - sat) : sat;
    end

    // cordic rotation terms
    always_comb
    begin
        ang   = cmd.sel ? {1'b0, hd_reg[31:1]} : hd_reg;
        flip  = ang[31] ^ ang[30];
        z0    = {{3{ang[31] ^ flip}}, ang[30:0]};
        xs    = cx_reg >>> cmd.step;
        ys    = cy_reg >>> cmd.step;
        at    = {4'd0, atan_bam(cmd.step)};
        cxc   = clamp_q30(cx_reg);
        cyc   = clamp_q30(cy_reg);
        c_res = cflip_reg ? (32'sd0 - cxc) : cxc;
        s_res = cflip_reg ? (32'sd0 - cyc) : cyc;
    end

    // position step and heading step
    always_comb
    begin
        sum78 = {sacc_reg, 16'd0} + {31'd0, prod_reg[46:0]};
        m48   = sum78[77:30];
        delta = (tneg_reg ^ f_neg) ? (48'd0 - m48) : m48;
        bam   = bacc_reg[63:32];
        hstep = dneg_reg ? (32'd0 - bam) : bam;
    end

    // pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg  <= '0;
            y_reg  <= '0;
            hd_reg <= '0;
        end
        else if (cmd.op == OP_ADD_POS)
        begin
            if (cmd.sel)
            begin
                y_reg  <= y_reg + delta;
                hd_reg <= hd_reg + hstep;
            end
            else
            begin
                x_reg <= x_reg + delta;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        unique case (cmd.op)
            OP_LOAD:
            begin
                dt_reg <= elapsed_time;
                ls_reg <= left_speed;
                rs_reg <= right_speed;
            end
            OP_ST_DL:
            begin
                dl_reg <= dl_next;
            end
            OP_ST_DR:
            begin
                dr_reg <= dr_next;
            end
            OP_SUMS:
            begin
                tmag_reg    <= smag49[47:1];
                tneg_reg    <= sum49[48] && (smag49[47:1] != 47'd0);
                dneg_reg    <= diff49[48];
                div_rem_reg <= '0;
                div_dvd_reg <= {dmag49[47:0], 16'd0};
                div_dsr_reg <= (wheel_base == 32'd0) ? 32'd1 : wheel_base;
                div_quo_reg <= '0;
                div_ovf_reg <= 1'b0;
            end
            OP_DIV_STEP:
            begin
                div_rem_reg <= rem_next;
                div_dvd_reg <= {div_dvd_reg[62:0], 1'b0};
                div_quo_reg <= {div_quo_reg[62:0], ge};
            end
            OP_MUL_B0:
            begin
                turn_reg <= div_quo_reg;
            end
            OP_ACC_B0:
            begin
                bacc_reg <= prod_reg;
            end
            OP_ACC_B1, OP_ACC_B2:
            begin
                bacc_reg[63:32] <= bacc_reg[63:32] + prod_reg[31:0];
            end
            OP_COR_INIT:
            begin
                cx_reg    <= CORDIC_START;
                cy_reg    <= '0;
                cz_reg    <= z0;
                cflip_reg <= flip;
            end
            OP_COR_STEP:
            begin
                if (!cz_reg[33])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + at;
                end
            end
            OP_COR_DONE:
            begin
                if (cmd.sel)
                begin
                    qw_reg <= c_res;
                    qz_reg <= s_res;
                end
                else
                begin
                    cos_reg <= c_res;
                    sin_reg <= s_res;
                end
            end
            OP_MUL_L:
            begin
                sacc_reg <= prod_reg[61:0];
            end
            OP_DIV_INIT:
            begin
                div_rem_reg <= m_hi[31:0];
                div_dvd_reg <= {m64[15:0], 48'd0};
                div_dsr_reg <= dt_reg;
                div_quo_reg <= '0;
                div_ovf_reg <= (m_hi >= {16'd0, dt_reg});
            end
            OP_DIV_FIN:
            begin
                if (cmd.sel)
                begin
                    rate_reg <= sres;
                end
                else
                begin
                    lin_reg <= sres;
                end
            end
            OP_OUT:
            begin
                ox_reg    <= x_reg;
                oy_reg    <= y_reg;
                ohd_reg   <= hd_reg;
                oqz_reg   <= qz_reg;
                oqw_reg   <= qw_reg;
                olin_reg  <= stat.dt_zero ? 32'sd0 : lin_reg;
                orate_reg <= stat.dt_zero ? 32'sd0 : rate_reg;
                ozero_reg <= stat.dt_zero;
            end
            default:
            begin
            end
        endcase
    end

    assign pos_x        = ox_reg;
    assign pos_y        = oy_reg;
    assign heading      = ohd_reg;
    assign quat_z       = oqz_reg;
    assign quat_w       = oqw_reg;
    assign linear_speed = olin_reg;
    assign turn_rate    = orate_reg;
    assign zero_time    = ozero_reg;

endmodule

@@ rtl/core/differential_drive_odometry_core.sv @@
// top level of the differential drive odometry core with its register port
// a transaction runs through the 64-step turn divider, two cordic passes of CORDIC_STEPS rotations
//   and two 32-step velocity divisions, each on one shared unit; both velocity divisions are skipped
//   when elapsed_time is zero. One transaction at a time: a new one is taken only after the last
//   result is loaded into the output slot, which waits while an earlier result has not been taken
// reset clears pose and heading to zero and wheel_base to 15729; no clearing pass
module differential_drive_odometry_core import ddo_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    ddo_in_if.sink      din,
    ddo_out_if.source   dout,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] wheel_base_reg, wheel_base_next;
    logic        cfg_wr;
    ddo_cmd_t    cmd;
    ddo_stat_t   stat;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == 1'(REG_WHEEL_BASE)) ? wheel_base_reg : 32'd0;

    always_comb
    begin
        wheel_base_next = wheel_base_reg;
        if (cfg_wr && (paddr[2] == 1'(REG_WHEEL_BASE)))
        begin
            wheel_base_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_base_reg <= WHEEL_BASE_RESET;
        end
        else
        begin
            wheel_base_reg <= wheel_base_next;
        end
    end

    // sequencer
    ddo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    ddo_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .wheel_base   (wheel_base_reg),
        .elapsed_time (din.elapsed_time),
        .left_speed   (din.left_speed),
        .right_speed  (din.right_speed),
        .pos_x        (dout.pos_x),
        .pos_y        (dout.pos_y),
        .heading      (dout.heading),
        .quat_z       (dout.quat_z),
        .quat_w       (dout.quat_w),
        .linear_speed (dout.linear_speed),
        .turn_rate    (dout.turn_rate),
        .zero_time    (dout.zero_time)
    );

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> !din.ready)
        else $error("input taken again right after a transaction");

    // zero elapsed time forces both velocities to zero
    a_zero_time_speeds: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.zero_time) |-> (dout.linear_speed == 32'sd0 &&
                                            dout.turn_rate == 32'sd0))
        else $error("velocity nonzero with zero elapsed time");

    // quaternion terms stay within the clamp
    a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> ($signed(dout.quat_w) <= 32'sd1073741824 &&
                        $signed(dout.quat_w) >= -32'sd1073741824 &&
                        $signed(dout.quat_z) <= 32'sd1073741824 &&
                        $signed(dout.quat_z) >= -32'sd1073741824))
        else $error("quaternion term out of range");

endmodule

@@ verif/differential_drive_odometry_core_test.sv @@
// testbench for the differential drive odometry core: directed table, random drives, pose predictor
module differential_drive_odometry_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ddo_pkg::*;

    localparam logic [2:0] ADDR_WHEEL_BASE = 3'(4 * REG_WHEEL_BASE);
    localparam logic [2:0] ADDR_UNUSED     = 3'd4;
    localparam int         RANDOM_ITEMS    = 650;
    localparam int         QUIET_AFTER     = 550;
    localparam int         HOLD_CYCLES     = 700;

    localparam longint ATAN_TAB [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
        5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef struct {
        logic        [47:0] pos_x;
        logic        [47:0] pos_y;
        logic        [31:0] heading;
        logic        [31:0] quat_z;
        logic        [31:0] quat_w;
        logic        [31:0] linear_speed;
        logic        [31:0] turn_rate;
        logic               zero_time;
    } pose_t;

    typedef struct {
        logic        [31:0] dt;
        logic signed [31:0] ls;
        logic signed [31:0] rs;
        bit                 stopped;
    } drive_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ddo_in_if  din();
    ddo_out_if dout();

    differential_drive_odometry_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din.sink),
        .dout    (dout.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [31:0] wb_model;
    logic [47:0] x_model;
    logic [47:0] y_model;
    logic [31:0] hd_model;

    pose_t pose_q[$];
    int    mismatches;
    bit    quiet;
    bit    hold_now;

    // directed drives: stopped rows have zero velocities and the flag known
    drive_row_t drive_tab [14] = '{
        '{32'd0,          32'sh7FFFFFFF, 32'sh80000000, 1'b1},
        '{32'd0,          32'sd0,        32'sd0,        1'b1},
        '{32'h00010000,   32'sd65536,    32'sd65536,    1'b0},
        '{32'h00010000,  -32'sd65536,    32'sd65536,    1'b0},
        '{32'h00010000,   32'sd65536,   -32'sd65536,    1'b0},
        '{32'hFFFFFFFF,   32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0},
        '{32'hFFFFFFFF,   32'sh80000000, 32'sh80000000, 1'b0},
        '{32'd1,          32'sh80000000, 32'sh7FFFFFFF, 1'b0},
        '{32'hFFFFFFFF,   32'sh80000000, 32'sh7FFFFFFF, 1'b0},
        '{32'd1,          32'sd1,        32'sd1,        1'b0},
        '{32'h00008000,   32'sd65536,    32'sd196608,   1'b0},
        '{32'd6554,       32'sd98304,    32'sd65536,    1'b0},
        '{32'hFFFFFFFF,   32'sd0,        32'sd0,        1'b0},
        '{32'h00010000,  -32'sd131072,  -32'sd131072,   1'b0}
    };

    function automatic longint unsigned magn(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint apply_sign(longint unsigned m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // sine and cosine of a binary angle, Q1.30
    function automatic void sin_cos(input logic [31:0] ang, output longint s, output longint c);
        logic [1:0] quad;
        bit         flip;
        longint     x;
        longint     y;
        longint     z;
        longint     nx;
        quad = ang[31:30];
        flip = (quad == 2'd1) || (quad == 2'd2);
        if (flip)
            ang = ang + 32'h80000000;
        z = longint'($signed(ang));
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_TAB[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_TAB[i];
            end
            x = nx;
        end
        if (x > 1073741824) x = 1073741824;
        if (x < -1073741824) x = -1073741824;
        if (y > 1073741824) y = 1073741824;
        if (y < -1073741824) y = -1073741824;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // travel times a Q1.30 factor, truncated toward zero
    function automatic longint travel_part(longint t, longint f);
        longint unsigned tm;
        longint unsigned fm;
        longint unsigned a;
        longint unsigned b;
        longint unsigned m;
        tm = magn(t);
        fm = magn(f);
        a  = (tm >> 16) * fm;
        b  = (tm & 64'hFFFF) * fm;
        m  = (a >> 14) + ((((a & 64'h3FFF) << 16) + b) >> 30);
        return apply_sign(m, (t < 0) != (f < 0));
    endfunction

    // Q.16 magnitude over elapsed time, saturated to 32 bits
    function automatic longint rate_of(longint unsigned m, bit neg, longint unsigned den);
        longint unsigned q;
        longint unsigned v;
        longint unsigned lim;
        q   = m / den;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (q >= 65536)
            v = lim;
        else
        begin
            v = (q << 16) + (((m % den) << 16) / den);
            if (v > lim)
                v = lim;
        end
        return apply_sign(v, neg);
    endfunction

    // advances the pose by one drive update and returns the expected result
    function automatic pose_t advance_pose(logic [31:0] dt, logic signed [31:0] ls,
                                           logic signed [31:0] rs);
        pose_t           r;
        longint unsigned dtu;
        longint          dl;
        longint          dr;
        longint          sum;
        longint          diff;
        longint          trav;
        longint unsigned wb;
        longint unsigned dm;
        longint unsigned turn_mag;
        logic [31:0]     step;
        longint          s;
        longint          c;
        longint          lin;
        longint          rate;
        dtu  = dt;
        dl   = apply_sign((dtu * magn(longint'(ls))) >> 16, ls < 0);
        dr   = apply_sign((dtu * magn(longint'(rs))) >> 16, rs < 0);
        sum  = dl + dr;
        diff = dr - dl;
        trav = apply_sign(magn(sum) >> 1, sum < 0);
        wb   = (wb_model == 0) ? 64'd1 : longint'(wb_model);
        dm   = magn(diff);
        turn_mag = ((dm / wb) << 16) + (((dm % wb) << 16) / wb);
        step = 32'((turn_mag * 64'd44798133900177) >> 32);
        sin_cos(hd_model, s, c);
        x_model  = x_model + 48'(travel_part(trav, c));
        y_model  = y_model + 48'(travel_part(trav, s));
        hd_model = (diff < 0) ? hd_model - step : hd_model + step;
        sin_cos({1'b0, hd_model[31:1]}, s, c);
        lin  = 0;
        rate = 0;
        if (dt != 0)
        begin
            lin  = rate_of(magn(trav), trav < 0, dtu);
            rate = rate_of(turn_mag, diff < 0, dtu);
        end
        r.pos_x        = x_model;
        r.pos_y        = y_model;
        r.heading      = hd_model;
        r.quat_z       = 32'(s);
        r.quat_w       = 32'(c);
        r.linear_speed = 32'(lin);
        r.turn_rate    = 32'(rate);
        r.zero_time    = (dt == 0);
        return r;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // time limit
    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    // offers one drive update and records its expected pose once taken
    task automatic send_drive(logic [31:0] dt, logic signed [31:0] ls,
                              logic signed [31:0] rs, bit stopped);
        pose_t p;
        int    gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            din.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din.valid        <= 1'b1;
        din.elapsed_time <= dt;
        din.left_speed   <= ls;
        din.right_speed  <= rs;
        do @(posedge clk); while (!din.ready);
        p = advance_pose(dt, ls, rs);
        if (stopped)
        begin
            p.linear_speed = '0;
            p.turn_rate    = '0;
            p.zero_time    = 1'b1;
        end
        pose_q.insert(pose_q.size(), p);
    endtask

    task automatic wait_idle();
        din.valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_WHEEL_BASE)
            wb_model = value;
    endtask

    task automatic random_drive();
        logic [31:0]        dt;
        logic signed [31:0] ls;
        logic signed [31:0] rs;
        dt = ($urandom_range(0, 7) == 0) ? $urandom() : 32'($urandom_range(0, 131072));
        if ($urandom_range(0, 15) == 0)
            dt = 0;
        ls = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 393216)) - 196608;
        rs = ($urandom_range(0, 2) == 0) ? ls + 32'($urandom_range(0, 8192)) - 4096
                                         : (($urandom_range(0, 3) == 0) ? $urandom()
                                           : 32'($urandom_range(0, 393216)) - 196608);
        send_drive(dt, ls, rs, 1'b0);
    endtask

    // stimulus
    initial
    begin
        logic [31:0] bases [5];
        int          sent;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        din.valid        = 1'b0;
        din.elapsed_time = '0;
        din.left_speed   = '0;
        din.right_speed  = '0;
        quiet            = 1'b0;
        hold_now         = 1'b0;
        mismatches       = 0;
        wb_model         = WHEEL_BASE_RESET;
        x_model          = '0;
        y_model          = '0;
        hd_model         = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset wheel base
        foreach (drive_tab[i])
            send_drive(drive_tab[i].dt, drive_tab[i].ls, drive_tab[i].rs, drive_tab[i].stopped);
        wait_idle();

        // zero wheel base acts as one lsb, then the widest base
        write_reg(ADDR_WHEEL_BASE, 32'd0);
        for (int i = 2; i < 6; i++)
            send_drive(drive_tab[i].dt, drive_tab[i].ls, drive_tab[i].rs, 1'b0);
        wait_idle();
        write_reg(ADDR_WHEEL_BASE, 32'hFFFFFFFF);
        write_reg(ADDR_UNUSED, 32'h12345678);
        for (int i = 7; i < 10; i++)
            send_drive(drive_tab[i].dt, drive_tab[i].ls, drive_tab[i].rs, 1'b0);
        wait_idle();

        // random phases over several wheel bases
        bases = '{32'd15729, 32'd1, $urandom(), 32'hFFFFFFFF, 32'($urandom_range(1000, 200000))};
        sent  = 0;
        foreach (bases[b])
        begin
            write_reg(ADDR_WHEEL_BASE, bases[b]);
            if (b == 1)
                hold_now = 1'b1;
            for (int k = 0; k < RANDOM_ITEMS / 5; k++)
            begin
                if (sent >= QUIET_AFTER)
                    quiet = 1'b1;
                random_drive();
                sent++;
            end
            wait_idle();
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // result side readiness, with one long hold-off
    initial
    begin
        dout.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_now)
            begin
                dout.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_now = 1'b0;
            end
            else if (quiet)
            begin
                dout.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                dout.ready <= ($urandom_range(0, 3) != 0);
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // result check against the oldest expected pose
    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && dout.valid && dout.ready)
        begin
            if (pose_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction at %0t", $realtime);
            end
            else
            begin
                e = pose_q.pop_front();
                if (dout.pos_x !== e.pos_x || dout.pos_y !== e.pos_y
                    || dout.heading !== e.heading || dout.quat_z !== e.quat_z
                    || dout.quat_w !== e.quat_w || dout.linear_speed !== e.linear_speed
                    || dout.turn_rate !== e.turn_rate || dout.zero_time !== e.zero_time)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: exp x=%h y=%h h=%h qz=%h qw=%h v=%h w=%h z=%b",
                                 $realtime, e.pos_x, e.pos_y, e.heading, e.quat_z, e.quat_w,
                                 e.linear_speed, e.turn_rate, e.zero_time,
                                 "\n    got x=%h y=%h h=%h qz=%h qw=%h v=%h w=%h z=%b",
                                 dout.pos_x, dout.pos_y, dout.heading, dout.quat_z,
                                 dout.quat_w, dout.linear_speed, dout.turn_rate,
                                 dout.zero_time);
                end
            end
        end
    end

endmodule
